/* rtl/record_frame_stack_top_assert.svh */
// Assertion macros shared by the record frame stack checker.
`ifndef RECORD_FRAME_STACK_TOP_ASSERT_SVH
`define RECORD_FRAME_STACK_TOP_ASSERT_SVH

// Implication in the same cycle, sampled on the rising clock edge outside reset.
`define RFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define RFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rfs_pkg.sv */
// Shared constants, codes and control types of the record frame stack.
`timescale 1ns / 1ps
package rfs_pkg;

  localparam int STACK_WORDS      = 4096;
  localparam int MAX_RECORD_WORDS = 64;
  localparam int WORD_W           = 32;
  localparam int LEN_W            = 7;
  localparam int STATUS_W         = 2;
  localparam int ADDR_W           = $clog2(STACK_WORDS);
  localparam int LEVEL_W          = $clog2(STACK_WORDS + 1);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_POP_DATA  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic push_ok;
    logic push_ovf;
    logic pop_start;
    logic pop_unf;
    logic pop_word;
  } cmd_t;

  typedef struct packed {
    logic load_ok;
    logic full;
    logic short_pop;
    logic cnt_last;
  } sts_t;

endpackage

/* rtl/rfs_in_if.sv */
// Input channel interface: operation and word with valid/ready.
`timescale 1ns / 1ps
interface rfs_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic signed [rfs_pkg::WORD_W-1:0] in_word;

  modport source (output valid, output operation, output in_word, input ready);
  modport sink (input valid, input operation, input in_word, output ready);
endinterface

/* rtl/rfs_out_if.sv */
// Result channel interface: word, status and last flag with valid/ready.
`timescale 1ns / 1ps
interface rfs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rfs_pkg::WORD_W-1:0]   out_word;
  logic        [rfs_pkg::STATUS_W-1:0] status;
  logic                                last_word;

  modport source (output valid, output out_word, output status, output last_word, input ready);
  modport sink (input valid, input out_word, input status, input last_word, output ready);
endinterface

/* rtl/rfs_datapath.sv */
// Datapath: word memory, fill level, pop address and count, result register.
`timescale 1ns / 1ps
module rfs_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic        [rfs_pkg::LEN_W-1:0]    cfg_data,
  input  logic signed [rfs_pkg::WORD_W-1:0]   in_word,
  input  rfs_pkg::cmd_t                       cmd,
  output rfs_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rfs_pkg::WORD_W-1:0]   out_word,
  output logic        [rfs_pkg::STATUS_W-1:0] out_status,
  output logic                                out_last
);

  logic        [rfs_pkg::WORD_W-1:0]   mem [rfs_pkg::STACK_WORDS];
  logic        [rfs_pkg::LEN_W-1:0]    rec_words_r;
  logic        [rfs_pkg::LEN_W-1:0]    eff_len;
  logic        [rfs_pkg::LEVEL_W-1:0]  fill_r;
  logic        [rfs_pkg::LEVEL_W-1:0]  fill_nxt;
  logic        [rfs_pkg::LEVEL_W-1:0]  pop_base;
  logic        [rfs_pkg::ADDR_W-1:0]   addr_r;
  logic        [rfs_pkg::LEN_W-1:0]    cnt_r;
  logic                                out_valid_r;
  logic                                out_zero_r;
  logic        [rfs_pkg::STATUS_W-1:0] out_status_r;
  logic                                out_last_r;
  logic        [rfs_pkg::WORD_W-1:0]   rd_data_r;
  logic                                load;

  always_comb begin
    if (rec_words_r == '0) begin
      eff_len = rfs_pkg::LEN_W'(1);
    end else if (rec_words_r > rfs_pkg::LEN_W'(rfs_pkg::MAX_RECORD_WORDS)) begin
      eff_len = rfs_pkg::LEN_W'(rfs_pkg::MAX_RECORD_WORDS);
    end else begin
      eff_len = rec_words_r;
    end
  end

  assign pop_base = fill_r - rfs_pkg::LEVEL_W'(eff_len);
  assign load     = cmd.push_ok | cmd.push_ovf | cmd.pop_unf | cmd.pop_word;

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.push_ok) begin
      fill_nxt = fill_r + rfs_pkg::LEVEL_W'(1);
    end else if (cmd.pop_start) begin
      fill_nxt = pop_base;
    end
  end

  assign sts.load_ok   = !out_valid_r || out_ready;
  assign sts.full      = (fill_r == rfs_pkg::LEVEL_W'(rfs_pkg::STACK_WORDS));
  assign sts.short_pop = (fill_r < rfs_pkg::LEVEL_W'(eff_len));
  assign sts.cnt_last  = (cnt_r == rfs_pkg::LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_words_r <= rfs_pkg::LEN_W'(1);
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rec_words_r <= cfg_data;
      end
      fill_r <= fill_nxt;
      if (cmd.pop_start) begin
        cnt_r <= eff_len;
      end else if (cmd.pop_word) begin
        cnt_r <= cnt_r - rfs_pkg::LEN_W'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_start) begin
      addr_r <= pop_base[rfs_pkg::ADDR_W-1:0];
    end else if (cmd.pop_word) begin
      addr_r <= addr_r + rfs_pkg::ADDR_W'(1);
    end
    if (load) begin
      out_zero_r <= !cmd.pop_word;
      out_last_r <= !cmd.pop_word || sts.cnt_last;
      if (cmd.pop_word) begin
        out_status_r <= rfs_pkg::ST_POP_DATA;
      end else if (cmd.push_ok) begin
        out_status_r <= rfs_pkg::ST_PUSH_OK;
      end else if (cmd.pop_unf) begin
        out_status_r <= rfs_pkg::ST_UNDERFLOW;
      end else begin
        out_status_r <= rfs_pkg::ST_OVERFLOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_ok) begin
      mem[fill_r[rfs_pkg::ADDR_W-1:0]] <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_word) begin
      rd_data_r <= mem[addr_r];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_word   = out_zero_r ? '0 : $signed(rd_data_r);
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

/* rtl/rfs_ctrl.sv */
// Controller: accepts items and sequences the words of a pop.
`timescale 1ns / 1ps
module rfs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          operation,
  output logic          in_ready,
  input  rfs_pkg::sts_t sts,
  output rfs_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.load_ok;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (operation == rfs_pkg::OP_PUSH) begin
            if (sts.full) begin
              cmd.push_ovf = 1'b1;
            end else begin
              cmd.push_ok = 1'b1;
            end
          end else if (sts.short_pop) begin
            cmd.pop_unf = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
            state_nxt     = S_POP;
          end
        end
      end
      S_POP: begin
        if (sts.load_ok) begin
          cmd.pop_word = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/record_frame_stack_top.sv */
// Top level of the record frame stack: controller, datapath and channel ports.
// A push or a rejected pop loads the result register, which shows its result in the next cycle.
// A pop of N words first sets up the address and count, then does one memory read per word taken.
// Pushes sustain one transfer per cycle while results are taken; pop words flow at the same rate.
// Reset clears the stack to empty and the record length to one word; memory contents are kept.
`timescale 1ns / 1ps
module record_frame_stack_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rfs_pkg::LEN_W-1:0]        cfg_data,
  rfs_in_if.sink                           in_ch,
  rfs_out_if.source                        out_ch
);

  rfs_pkg::cmd_t cmd;
  rfs_pkg::sts_t sts;

  rfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .operation (in_ch.operation),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rfs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_word    (in_ch.in_word),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_word   (out_ch.out_word),
    .out_status (out_ch.status),
    .out_last   (out_ch.last_word)
  );

endmodule

/* rtl/rfs_checker.sv */
// Port-level checker for the record frame stack and its bind to the top level.
`timescale 1ns / 1ps
`include "record_frame_stack_top_assert.svh"
module rfs_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rfs_pkg::WORD_W-1:0]   out_word,
  input logic        [rfs_pkg::STATUS_W-1:0] status,
  input logic                                last_word
);

  `RFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(status), "stalled result changed")
  `RFS_ASSERT_NOW(a_zero_word, out_valid && (status != rfs_pkg::ST_POP_DATA), out_word == '0, "non-pop result carries a word")
  `RFS_ASSERT_NOW(a_single_last, out_valid && (status != rfs_pkg::ST_POP_DATA), last_word, "single result without last flag")
  `RFS_ASSERT_NOW(a_no_accept_stall, out_valid && !out_ready, !in_ready, "input taken while result stalled")

endmodule

bind record_frame_stack_top rfs_checker u_rfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.out_word),
  .status    (out_ch.status),
  .last_word (out_ch.last_word)
);

/* tb/sv/record_frame_stack_top_test.sv */
// Self-checking testbench for the record frame stack with randomized handshakes.
`timescale 1ns / 1ps
module record_frame_stack_top_test;

  typedef struct packed {
    logic                      op;
    logic [rfs_pkg::WORD_W-1:0] word;
  } stack_op_t;

  typedef struct packed {
    logic [rfs_pkg::WORD_W-1:0]   word;
    logic [rfs_pkg::STATUS_W-1:0] status;
    logic                         last;
  } stack_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [rfs_pkg::LEN_W-1:0] cfg_data;

  rfs_in_if  in_ch();
  rfs_out_if out_ch();

  record_frame_stack_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  stack_op_t     stack_ops_q[$];
  stack_result_t stack_results_q[$];

  logic [rfs_pkg::WORD_W-1:0] shadow_store [rfs_pkg::STACK_WORDS];
  int unsigned                shadow_level = 0;
  logic [rfs_pkg::LEN_W-1:0]  shadow_len = 7'd1;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned in_transfers = 0;
  int unsigned out_transfers = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic int unsigned effective_len(input logic [rfs_pkg::LEN_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > rfs_pkg::LEN_W'(rfs_pkg::MAX_RECORD_WORDS)) begin
      return rfs_pkg::MAX_RECORD_WORDS;
    end
    return int'(v);
  endfunction

  function automatic void predict_stack_op(input logic op,
                                           input logic [rfs_pkg::WORD_W-1:0] word);
    int unsigned len;
    int unsigned start;
    if (op == rfs_pkg::OP_PUSH) begin
      if (shadow_level >= rfs_pkg::STACK_WORDS) begin
        stack_results_q.push_back('{word: '0, status: rfs_pkg::ST_OVERFLOW, last: 1'b1});
      end else begin
        shadow_store[shadow_level] = word;
        shadow_level++;
        stack_results_q.push_back('{word: '0, status: rfs_pkg::ST_PUSH_OK, last: 1'b1});
      end
    end else begin
      len = effective_len(shadow_len);
      if (shadow_level < len) begin
        stack_results_q.push_back('{word: '0, status: rfs_pkg::ST_UNDERFLOW, last: 1'b1});
      end else begin
        start = shadow_level - len;
        for (int unsigned i = 0; i < len; i++) begin
          stack_results_q.push_back('{word: shadow_store[start + i],
                                      status: rfs_pkg::ST_POP_DATA,
                                      last: (i + 1 == len)});
        end
        shadow_level = start;
      end
    end
  endfunction

  always @(posedge clk) begin : drive_ops
    stack_op_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (stack_ops_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = stack_ops_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.operation <= nxt.op;
        in_ch.in_word   <= nxt.word;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_results
    stack_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (cfg_we) begin
        shadow_len = cfg_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        in_transfers++;
        predict_stack_op(in_ch.operation, in_ch.in_word);
      end
      if (out_ch.valid && out_ch.ready) begin
        out_transfers++;
        if (stack_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word=%h status=%0d last=%b",
                                    out_ch.out_word, out_ch.status, out_ch.last_word));
        end else begin
          exp_r = stack_results_q.pop_front();
          status_seen[exp_r.status]++;
          if (out_ch.out_word !== exp_r.word) begin
            report_mismatch($sformatf("out_word %h, expected %h", out_ch.out_word, exp_r.word));
          end
          if (out_ch.status !== exp_r.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_ch.status, exp_r.status));
          end
          if (out_ch.last_word !== exp_r.last) begin
            report_mismatch($sformatf("last_word %b, expected %b", out_ch.last_word, exp_r.last));
          end
        end
      end
    end
  end

  task automatic queue_op(input logic op, input logic [rfs_pkg::WORD_W-1:0] word);
    stack_ops_q.push_back('{op: op, word: word});
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (stack_ops_q.size() != 0 || in_ch.valid || stack_results_q.size() != 0);
  endtask

  task automatic set_record_len(input logic [rfs_pkg::LEN_W-1:0] v);
    wait_idle();
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly runs of up to two records of pushes, usually followed by a pop, mixed with stray operations.
  task automatic run_random(input logic [rfs_pkg::LEN_W-1:0] len_cfg,
                            input int unsigned budget);
    int unsigned eff;
    int unsigned k;
    int unsigned n;
    set_record_len(len_cfg);
    eff = effective_len(len_cfg);
    n = 0;
    while (n < budget) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(2 * eff, 1);
        repeat (k) queue_op(rfs_pkg::OP_PUSH, $urandom);
        n += k;
        if ($urandom_range(99) < 80) begin
          queue_op(rfs_pkg::OP_POP, $urandom);
          n++;
        end
      end else begin
        queue_op(1'($urandom_range(1, 0)), $urandom);
        n++;
      end
      if ($urandom_range(24) == 0) begin
        wait_idle();
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = rfs_pkg::OP_PUSH;
    in_ch.in_word   = '0;
    out_ch.ready    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 74;
    queue_op(rfs_pkg::OP_POP, 32'h0000_0000);
    queue_op(rfs_pkg::OP_PUSH, 32'h7FFF_FFFF);
    queue_op(rfs_pkg::OP_PUSH, 32'h8000_0000);
    queue_op(rfs_pkg::OP_PUSH, 32'h0000_0000);
    queue_op(rfs_pkg::OP_PUSH, 32'hFFFF_FFFF);
    queue_op(rfs_pkg::OP_PUSH, 32'h0000_0001);
    queue_op(rfs_pkg::OP_PUSH, 32'hAAAA_AAAA);
    queue_op(rfs_pkg::OP_PUSH, 32'h5555_5555);
    queue_op(rfs_pkg::OP_POP, 32'hFFFF_FFFF);
    set_record_len(7'd3);
    queue_op(rfs_pkg::OP_POP, 32'h0000_0000);
    queue_op(rfs_pkg::OP_POP, 32'h0000_0000);
    queue_op(rfs_pkg::OP_POP, 32'h0000_0000);
    set_record_len(7'd0);
    queue_op(rfs_pkg::OP_PUSH, 32'h1234_5678);
    queue_op(rfs_pkg::OP_POP, 32'h0000_0000);
    queue_op(rfs_pkg::OP_POP, 32'h0000_0000);
    set_record_len(7'd127);
    queue_op(rfs_pkg::OP_PUSH, 32'hDEAD_BEEF);
    queue_op(rfs_pkg::OP_POP, 32'h0000_0000);

    run_random(7'd2, 70);
    run_random(7'd5, 70);

    wait_idle();
    send_idle_pct = 74;
    recv_idle_pct = 11;
    run_random(7'd64, 80);
    run_random(7'd1, 70);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(7'd65, 70);

    run_random(7'd0, 40);

    wait_idle();
    repeat (70) @(negedge clk);
    if (stack_results_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", stack_results_q.size()));
    end
    $display("Covered %0d input transfers and %0d result transfers over record lengths 0 to 127.",
             in_transfers, out_transfers);
    $display("Pop words %0d, pushes %0d, underflows %0d, overflows %0d; mismatches %0d.",
             status_seen[rfs_pkg::ST_POP_DATA], status_seen[rfs_pkg::ST_PUSH_OK],
             status_seen[rfs_pkg::ST_UNDERFLOW], status_seen[rfs_pkg::ST_OVERFLOW],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("record_frame_stack_top_test passed");
    end else begin
      $display("record_frame_stack_top_test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still expected.", stack_results_q.size());
    $display("record_frame_stack_top_test failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rfs_pkg.sv
rtl/rfs_in_if.sv
rtl/rfs_out_if.sv
rtl/rfs_datapath.sv
rtl/rfs_ctrl.sv
rtl/record_frame_stack_top.sv
rtl/rfs_checker.sv
tb/sv/record_frame_stack_top_test.sv
